### src/pfe_pkg.sv
// shared types and constants of the postfix expression evaluator
// no dependencies; imported by the front end, queue, back end, top level and testbench
`default_nettype none

package pfe_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;

   // decoupling queue between classifier and execution sequencer
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_LEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // ascii characters with a meaning
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
   localparam logic [1:0] STATUS_DIV_ZERO  = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] operand;
      logic       last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } item_beat_type;

endpackage

`default_nettype wire

### src/pfe_if.sv
// request and response channel interfaces of the postfix expression evaluator
// no dependencies
`default_nettype none

interface pfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfe_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] value;
   logic [1:0]        status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

### src/pfe_front.sv
// front end: accepts request beats and classifies each character
// depends on pfe_pkg and pfe_req_if
`default_nettype none

module pfe_front (
   input  wire logic            clock,
   input  wire logic            reset,
   pfe_req_if.sink              req_bus,
   output pfe_pkg::item_beat_type push_beat,
   input  wire logic            push_ready
);
   import pfe_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff, hold_item_in;
   item_type decoded;
   logic     req_fire;

   always_comb begin
      decoded.last    = req_bus.last;
      decoded.operand = req_bus.symbol - CHAR_ZERO;
      unique case (req_bus.symbol)
         CHAR_PLUS:  decoded.op = OP_ADD;
         CHAR_MINUS: decoded.op = OP_SUB;
         CHAR_STAR:  decoded.op = OP_MUL;
         CHAR_SLASH: decoded.op = OP_DIV;
         default:    decoded.op = OP_PUSH;
      endcase
   end

   assign req_bus.ready = !hold_valid_ff || push_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff && !push_ready;
      hold_item_in  = hold_item_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
         hold_item_in  = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

   assign push_beat.valid = hold_valid_ff;
   assign push_beat.item  = hold_item_ff;

endmodule

`default_nettype wire

### src/pfe_queue.sv
// short fifo of classified items between front end and back end
// depends on pfe_pkg
`default_nettype none

module pfe_queue (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pfe_pkg::item_beat_type              push_beat,
   output logic                                     push_ready,
   output pfe_pkg::item_beat_type                   pop_beat,
   input  wire logic                                pop_ready,
   output logic [pfe_pkg::QUEUE_LEVEL_WIDTH-1:0]    level
);
   import pfe_pkg::*;

   localparam logic [QUEUE_PTR_WIDTH-1:0]   PtrLast   = QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_LEVEL_WIDTH-1:0] LevelFull = QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH);

   item_type                     entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                         push_fire, pop_fire;

   function automatic logic [QUEUE_PTR_WIDTH-1:0] ptr_next(input logic [QUEUE_PTR_WIDTH-1:0] p);
      return (p == PtrLast) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (level_ff != LevelFull);
   assign push_fire  = push_beat.valid && push_ready;
   assign pop_fire   = pop_beat.valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push_fire && !pop_fire) begin
         level_in = level_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_beat.item;
      end
   end

   assign pop_beat.valid = (level_ff != '0);
   assign pop_beat.item  = entry_ff[rd_ptr_ff];
   assign level          = level_ff;

endmodule

`default_nettype wire

### src/pfe_back.sv
// back end: stack sequencer with iterative divider and response register
// depends on pfe_pkg and pfe_rsp_if
`default_nettype none

module pfe_back #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pfe_pkg::item_beat_type pop_beat,
   output logic                   pop_ready,
   pfe_rsp_if.source              rsp_bus
);
   import pfe_pkg::*;

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam int AddrWidth  = $clog2(STACK_DEPTH);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(STACK_DEPTH);
   localparam logic [CountWidth-1:0] CountTwo  = CountWidth'(2);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_DIV      = 3'd2;
   localparam logic [2:0] S_DIV_DONE = 3'd3;
   localparam logic [2:0] S_FINISH   = 3'd4;

   localparam logic [2:0] DivStepLast = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            error_ff, error_in;
   logic [7:0]            tos_ff, tos_in;
   op_type                op_ff, op_in;
   logic                  last_ff, last_in;
   logic [8:0]            rem_ff, rem_in;
   logic [7:0]            quo_ff, quo_in;
   logic [7:0]            den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [2:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   // stack body below the top entry; top lives in tos_ff
   logic [7:0]            stack_mem [STACK_DEPTH];
   logic [7:0]            rd_data_ff;
   logic                  mem_wr_en, mem_rd_en;
   logic [AddrWidth-1:0]  mem_wr_addr, mem_rd_addr;
   logic [CountWidth-1:0] count_less_one, count_less_two;

   logic [15:0]           product;
   logic [8:0]            rem_shift;

   function automatic logic [1:0] keep_first(input logic [1:0] cur, input logic [1:0] code);
      return (cur == STATUS_OK) ? code : cur;
   endfunction

   assign count_less_one = count_ff - CountWidth'(1);
   assign count_less_two = count_ff - CountWidth'(2);
   assign mem_wr_addr    = count_less_one[AddrWidth-1:0];
   assign mem_rd_addr    = count_less_two[AddrWidth-1:0];
   assign product        = rd_data_ff * tos_ff;
   assign rem_shift      = {rem_ff[7:0], quo_ff[7]};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      error_in      = error_ff;
      tos_in        = tos_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      pop_ready     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_beat.valid) begin
               pop_ready = 1'b1;
               op_in     = pop_beat.item.op;
               last_in   = pop_beat.item.last;
               state_in  = pop_beat.item.last ? S_FINISH : S_IDLE;
               // a first-error underflow stops the rest of the expression
               if (error_ff != STATUS_UNDERFLOW) begin
                  if (pop_beat.item.op == OP_PUSH) begin
                     if (count_ff == CountFull) begin
                        error_in = keep_first(error_ff, STATUS_OVERFLOW);
                     end else begin
                        mem_wr_en = (count_ff != '0);
                        tos_in    = pop_beat.item.operand;
                        count_in  = count_ff + 1'b1;
                     end
                  end else if (count_ff < CountTwo) begin
                     error_in = keep_first(error_ff, STATUS_UNDERFLOW);
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = S_EXEC;
                  end
               end
            end
         end
         S_EXEC: begin
            count_in = count_less_one;
            state_in = last_ff ? S_FINISH : S_IDLE;
            case (op_ff)
               OP_ADD: tos_in = rd_data_ff + tos_ff;
               OP_SUB: tos_in = rd_data_ff - tos_ff;
               OP_MUL: tos_in = product[7:0];
               OP_DIV: begin
                  if (tos_ff == '0) begin
                     tos_in   = '0;
                     error_in = keep_first(error_ff, STATUS_DIV_ZERO);
                  end else begin
                     quo_in   = rd_data_ff[7] ? (8'd0 - rd_data_ff) : rd_data_ff;
                     den_in   = tos_ff[7] ? (8'd0 - tos_ff) : tos_ff;
                     neg_in   = rd_data_ff[7] ^ tos_ff[7];
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = S_DIV;
                  end
               end
               default: tos_in = tos_ff;
            endcase
         end
         S_DIV: begin
            // restoring division on magnitudes, one quotient bit a cycle
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in = rem_shift - {1'b0, den_ff};
               quo_in = {quo_ff[6:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[6:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == DivStepLast) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            tos_in   = neg_ff ? (8'd0 - quo_ff) : quo_ff;
            state_in = last_ff ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = error_ff;
               if (error_ff != STATUS_UNDERFLOW) begin
                  if (count_ff == '0) begin
                     rsp_status_in = keep_first(error_ff, STATUS_UNDERFLOW);
                  end else begin
                     rsp_value_in = tos_ff;
                  end
               end
               count_in = '0;
               error_in = STATUS_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         error_ff     <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      op_ff         <= op_in;
      last_ff       <= last_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      step_ff       <= step_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         stack_mem[mem_wr_addr] <= tos_ff;
      end
      if (mem_rd_en) begin
         rd_data_ff <= stack_mem[mem_rd_addr];
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

endmodule

`default_nettype wire

### src/postfix_expression_evaluator.sv
// top level of the postfix expression evaluator: front end, queue, back end
// depends on pfe_pkg, pfe_if, pfe_front, pfe_queue and pfe_back
//
//   channel   dir   beat                    accepted when
//   req_bus   in    symbol[7:0], last       valid && ready
//   rsp_bus   out   value[7:0] s, status    valid && ready
//
// back end: operand push in idle; add/sub/mul read stack memory, then execute;
// divide adds the 8-step iterative divider and a sign fix-up state; divide by
// zero ends at execute; a last character then passes finish for the final pop
// front end and a 4-entry queue absorb bursts while the back end is busy
// synchronous active-high reset clears stack count, error and all valids;
// the stack memory itself is not cleared, only entries below the count are read
// a stalled response holds in its output register while further items are taken
`default_nettype none

module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   pfe_req_if.sink   req_bus,
   pfe_rsp_if.source rsp_bus
);
   import pfe_pkg::*;

   // front end to queue
   item_beat_type push_beat;
   logic          push_ready;

   // queue to back end
   item_beat_type pop_beat;
   logic          pop_ready;

   logic [QUEUE_LEVEL_WIDTH-1:0] q_level;
   logic                         push_fire, pop_fire;

   assign push_fire = push_beat.valid && push_ready;
   assign pop_fire  = pop_beat.valid && pop_ready;

   pfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_beat  (push_beat),
      .push_ready (push_ready)
   );

   pfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_beat  (push_beat),
      .push_ready (push_ready),
      .pop_beat   (pop_beat),
      .pop_ready  (pop_ready),
      .level      (q_level)
   );

   pfe_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_beat  (pop_beat),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

   // queue fill level never passes its depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= QUEUE_LEVEL_WIDTH'(QUEUE_DEPTH))
      else $error("queue level above depth");

   // fill level follows push and pop beats exactly
   a_level_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> q_level == QUEUE_LEVEL_WIDTH'($past(q_level) + $past(push_fire)
                                             - $past(pop_fire)))
      else $error("queue level out of step with beats");

   // reset empties the queue and withdraws any response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (q_level == '0) && !rsp_bus.valid)
      else $error("state left after reset");

endmodule

`default_nettype wire

### sim/tb_postfix_expression_evaluator.sv
`timescale 1ns / 100ps
// testbench of the postfix expression evaluator: random and directed expressions
// with a stack predictor and scoreboard; depends on pfe_pkg, pfe_if and the block

module tb_postfix_expression_evaluator;
   import pfe_pkg::*;

   localparam int DEPTH        = STACK_DEPTH_DEFAULT;
   localparam int ITEM_TARGET  = 1450;
   localparam int CALM_AT      = 1250;   // no idling on either side from here on
   localparam int HOLD_AT      = 420;    // long output stall starts here
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_AT     = 860;    // sender waits for every answer here
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [7:0] value;
      logic [1:0] status;
   } answer_type;

   // stack predictor plus the queue of answers it has worked out
   class postfix_checker;
      logic [7:0]  stack_mem [DEPTH];
      int unsigned fill;
      logic [1:0]  err;
      answer_type  answers [$];
      int unsigned mismatches;
      int unsigned status_seen [4];

      function new();
         fill       = 0;
         err        = STATUS_OK;
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function op_type classify(logic [7:0] sym);
         case (sym)
            CHAR_PLUS:  return OP_ADD;
            CHAR_MINUS: return OP_SUB;
            CHAR_STAR:  return OP_MUL;
            CHAR_SLASH: return OP_DIV;
            default:    return OP_PUSH;
         endcase
      endfunction

      function void flag(logic [1:0] code);
         if (err == STATUS_OK) err = code;
      endfunction

      function void push(logic [7:0] v);
         if (fill >= DEPTH) begin
            flag(STATUS_OVERFLOW);
            return;
         end
         stack_mem[fill] = v;
         fill++;
      endfunction

      function void apply(logic [7:0] sym);
         op_type op;
         int     lhs, rhs, res;
         op = classify(sym);
         if (op == OP_PUSH) begin
            push(sym - CHAR_ZERO);
            return;
         end
         if (fill < 2) begin
            flag(STATUS_UNDERFLOW);
            return;
         end
         rhs  = int'($signed(stack_mem[fill - 1]));
         lhs  = int'($signed(stack_mem[fill - 2]));
         fill = fill - 2;
         case (op)
            OP_ADD: res = lhs + rhs;
            OP_SUB: res = lhs - rhs;
            OP_MUL: res = lhs * rhs;
            default: begin
               if (rhs == 0) begin
                  flag(STATUS_DIV_ZERO);
                  res = 0;
               end else begin
                  res = lhs / rhs;
               end
            end
         endcase
         push(res[7:0]);
      endfunction

      // one accepted character; the last one yields an answer
      function void take_symbol(logic [7:0] sym, logic fin);
         answer_type ans;
         if (err != STATUS_UNDERFLOW) apply(sym);
         if (!fin) return;
         ans.value = 8'd0;
         if (err != STATUS_UNDERFLOW) begin
            if (fill == 0) begin
               flag(STATUS_UNDERFLOW);
            end else begin
               fill--;
               ans.value = stack_mem[fill];
            end
         end
         ans.status = err;
         answers.push_back(ans);
         fill = 0;
         err  = STATUS_OK;
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_result(logic [7:0] got_value, logic [1:0] got_status);
         answer_type want;
         if (answers.size() == 0) begin
            report($sformatf("unexpected result value %0d status %0d",
                             $signed(got_value), got_status));
            return;
         end
         want = answers.pop_front();
         status_seen[want.status]++;
         if (got_value !== want.value)
            report($sformatf("value %0d, predicted %0d",
                             $signed(got_value), $signed(want.value)));
         if (got_status !== want.status)
            report($sformatf("status %0d, predicted %0d", got_status, want.status));
      endtask

      function int outstanding();
         return answers.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   pfe_req_if req_bus ();
   pfe_rsp_if rsp_bus ();

   postfix_expression_evaluator DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   postfix_checker sb = new();

   logic [7:0]  expr_syms [$];
   int unsigned items_sent   = 0;
   int unsigned idle_chance  = 0;   // 0 means this expression goes back to back
   int unsigned cycle_count  = 0;
   int unsigned overflow_runs = 0;
   bit          calm         = 1'b0;
   bit          hold_rsp     = 1'b0;
   bit          drained      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers outstanding",
                  cycle_count, sb.outstanding());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result beats are checked against the oldest predicted answer
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.value, rsp_bus.status);
   end

   // receiver: random ready bursts, one long hold-off, none in the calm tail
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   function automatic logic [7:0] digit(int n);
      return CHAR_ZERO + 8'(n);
   endfunction

   function automatic bit is_operator(logic [7:0] sym);
      return sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR || sym == CHAR_SLASH;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 3))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   // mostly digits, some zeros for the divider, some arbitrary bytes
   function automatic logic [7:0] pick_operand();
      logic [7:0] sym;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: sym = digit($urandom_range(0, 9));
         6:                sym = CHAR_ZERO;
         default: begin
            sym = 8'($urandom_range(0, 255));
            while (is_operator(sym)) sym = 8'($urandom_range(0, 255));
         end
      endcase
      return sym;
   endfunction

   // well-formed postfix: operands and operators keep at least one value live
   function automatic void build_wellformed(int target);
      int live;
      live = 0;
      expr_syms.delete();
      while (!(live == 1 && expr_syms.size() >= target)) begin
         if (live < 2 || (live < 6 && expr_syms.size() < target && $urandom_range(0, 1) == 0)) begin
            expr_syms.push_back(pick_operand());
            live++;
         end else begin
            expr_syms.push_back(pick_operator());
            live--;
         end
      end
   endfunction

   // one character beat; gaps in front of it as this expression's idling allows
   task automatic send_item(input logic [7:0] sym, input logic fin);
      if (!calm && idle_chance != 0 && $urandom_range(0, 7) < idle_chance) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      req_bus.last   <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.take_symbol(sym, fin);
      items_sent++;
      if (items_sent == HOLD_AT) hold_rsp = 1'b1;
      if (items_sent >= CALM_AT) calm = 1'b1;
   endtask

   task automatic send_expression();
      foreach (expr_syms[i]) send_item(expr_syms[i], i == expr_syms.size() - 1);
   endtask

   // sender pauses until every answer so far has come back
   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int kind, spot;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.symbol <= 8'd0;
      req_bus.last   <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes as operands, each operator, the underflow and divide-by-zero cases
      idle_chance = 2;
      expr_syms = '{8'd0};
      send_expression();
      expr_syms = '{8'd255};
      send_expression();
      expr_syms = '{digit(1), digit(2), CHAR_PLUS};
      send_expression();
      expr_syms = '{digit(3), digit(4), CHAR_STAR};
      send_expression();
      // -7 / 2 truncates toward zero
      expr_syms = '{CHAR_ZERO - 8'd7, digit(2), CHAR_SLASH};
      send_expression();
      // -128 / -1 wraps back to -128; -1 is built as 0 - 1
      expr_syms = '{CHAR_ZERO - 8'd128, digit(0), digit(1), CHAR_MINUS, CHAR_SLASH};
      send_expression();
      // divide by zero pushes 0
      expr_syms = '{digit(5), digit(0), CHAR_SLASH};
      send_expression();
      // operator on an empty stack stops the expression
      expr_syms = '{CHAR_PLUS, digit(7)};
      send_expression();
      // divide by zero is kept over a later short operator
      expr_syms = '{digit(5), digit(0), CHAR_SLASH, CHAR_PLUS, digit(3)};
      send_expression();

      // random expressions until the item budget is spent
      while (items_sent < ITEM_TARGET) begin
         idle_chance = $urandom_range(0, 4);
         if (overflow_runs < 4 && items_sent >= 200 * (overflow_runs + 1)) begin
            // fill to one below, exactly at, and beyond the stack depth
            expr_syms.delete();
            repeat (DEPTH - 1 + overflow_runs + (overflow_runs == 3 ? 3 : 0))
               expr_syms.push_back(pick_operand());
            repeat ($urandom_range(0, 4)) expr_syms.push_back(pick_operator());
            overflow_runs++;
         end else begin
            kind = $urandom_range(0, 9);
            build_wellformed($urandom_range(1, 12));
            if (kind == 8) begin
               // broken: a stray operator somewhere, often one too many
               spot = $urandom_range(0, expr_syms.size());
               expr_syms.insert(spot, pick_operator());
            end else if (kind == 9) begin
               // noise: any bytes at all
               expr_syms.delete();
               repeat ($urandom_range(1, 6)) expr_syms.push_back(8'($urandom_range(0, 255)));
            end
         end
         send_expression();
         if (!drained && items_sent >= DRAIN_AT) begin
            drain_answers();
            drained = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d characters sent, answers by status: ok %0d, underflow %0d, overflow %0d, div0 %0d",
               items_sent, sb.status_seen[STATUS_OK], sb.status_seen[STATUS_UNDERFLOW],
               sb.status_seen[STATUS_OVERFLOW], sb.status_seen[STATUS_DIV_ZERO]);
      $display("%0d mismatches over %0d cycles, incl. long output stall and full stacks",
               sb.mismatches, cycle_count);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
